/* hw/rtl/pkc_pkg.sv */
package pkc_pkg;

    // Input item kinds (s_tuser)
    typedef enum logic [2:0] {
        FUNC_TICK   = 3'd0,
        FUNC_STATUS = 3'd1,
        FUNC_RSSI   = 3'd2,
        FUNC_KEY    = 3'd3,
        FUNC_MODE   = 3'd4
    } func_t;

    // Link status codes; values 5 to 7 are stored but drive nothing
    localparam logic [2:0] ST_ADV          = 3'd0;
    localparam logic [2:0] ST_CONNECTED    = 3'd1;
    localparam logic [2:0] ST_DISCONNECTED = 3'd2;
    localparam logic [2:0] ST_PAIRING      = 3'd3;
    localparam logic [2:0] ST_UNPAIRED     = 3'd4;
    localparam logic [2:0] ST_UNKNOWN      = 3'd7;

    // Key commands
    localparam logic [2:0] KEY_KEEP   = 3'd0;
    localparam logic [2:0] KEY_POWER  = 3'd1;
    localparam logic [2:0] KEY_UNLOCK = 3'd2;

    // LED patterns
    localparam logic [2:0] LED_DISCONNECT = 3'd0;
    localparam logic [2:0] LED_CONNECTED  = 3'd1;
    localparam logic [2:0] LED_PAIRING    = 3'd2;
    localparam logic [2:0] LED_UNPAIRED   = 3'd3;
    localparam logic [2:0] LED_SLEEP      = 3'd4;
    localparam logic [2:0] LED_KEEP       = 3'd5;
    localparam logic [2:0] LED_OPEN       = 3'd6;
    localparam logic [2:0] LED_CLOSE      = 3'd7;

    // Configuration register indexes
    localparam logic [2:0] REG_THR_ZERO     = 3'd0;
    localparam logic [2:0] REG_THR_ONE      = 3'd1;
    localparam logic [2:0] REG_THR_TWO      = 3'd2;
    localparam logic [2:0] REG_KEEP_LEN     = 3'd3;
    localparam logic [2:0] REG_IDLE_LIMIT   = 3'd4;
    localparam logic [2:0] REG_INITIAL_MODE = 3'd5;

    localparam logic signed [7:0] THR_RST        = 8'sd1;
    localparam logic [15:0]       KEEP_LEN_RST   = 16'd7200;
    localparam logic [15:0]       IDLE_LIMIT_RST = 16'd500;
    localparam logic [1:0]        MODE_RST       = 2'd0;
    localparam logic [1:0]        MODE_LAST      = 2'd2;
    localparam logic [15:0]       KEEP_END_TICKS = 16'd10;

    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 16;

    typedef struct packed {
        func_t              func;
        logic [2:0]         event_code;
        logic signed [7:0]  rssi;
        logic               switch_on;
    } item_t;

    // Packed so that power_on lands in bit 0
    typedef struct packed {
        logic       mode_changed;
        logic [1:0] mode_now;
        logic       sleep_request;
        logic [2:0] led_code;
        logic       led_valid;
        logic       lock_on;
        logic       power_on;
    } result_t;

    typedef struct packed {
        logic signed [7:0] thr_zero;
        logic signed [7:0] thr_one;
        logic signed [7:0] thr_two;
        logic [15:0]       keep_len;
        logic [15:0]       idle_limit;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        logic [2:0]  index;
        logic [15:0] data;
    } cfg_wr_t;

endpackage

/* hw/rtl/proximity_key_controller.sv */
// Proximity key controller: drives the power and lock lines of a keyless
// vehicle key from radio link events.
//
// Input channel (s_): one transaction is one event. s_tuser carries the
// event kind (tick, link status, RSSI report, key command, mode button),
// s_tdata the event code, RSSI and switch argument.
// Result channel (m_): exactly one transaction per input transaction, in
// order, with the line levels, LED pattern, sleep request and mode.
// Configuration channel (cfg_): register index and data, always ready;
// write only while no event is in flight.
//
// An event passes the input register, then the state update and the result
// register. Throughput: one event per cycle while m_tready is high; the
// state logic between the two registers is a single pass per event.
// When the receiver stalls the result register holds, the input register
// fills, and s_tready drops only when both are full.
// Reset (aresetn low, synchronous) empties both stages and loads the
// configuration and state with their reset values; no clearing pass.
module proximity_key_controller
    import pkc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // input events
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // [2:0] event_code, [10:3] rssi, [11] switch_on
    input  logic [2:0]             s_tuser,   // [2:0] func
    // results
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,   // [0] power_on, [1] lock_on, [2] led_valid,
                                              // [5:3] led_code, [6] sleep_request,
                                              // [8:7] mode_now, [9] mode_changed
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [15:0]            cfg_data
);

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    out_space;
    logic    step;
    logic    s_fire;
    cfg_t    cfg;
    cfg_wr_t cfg_wr;
    result_t res;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_wr.valid = cfg_valid && cfg_ready;
        cfg_wr.index = cfg_index;
        cfg_wr.data  = cfg_data;
    end

    // event leaves the input register when the result register has room
    assign step     = in_valid_reg && out_space;
    assign s_tready = !in_valid_reg || step;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.func       <= func_t'(s_tuser);
            in_item_reg.event_code <= s_tdata[2:0];
            in_item_reg.rssi       <= s_tdata[10:3];
            in_item_reg.switch_on  <= s_tdata[11];
        end
    end

    pkc_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (cfg_wr),
        .cfg     (cfg)
    );

    pkc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .wr      (cfg_wr),
        .step    (step),
        .item    (in_item_reg),
        .res     (res)
    );

    pkc_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step),
        .res      (res),
        .space    (out_space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    // an empty result register must never hold back the input side
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid) |-> s_tready)
        else $error("input stalled with empty result register");

    a_led_code_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[2]) |-> (m_tdata[5:3] == LED_DISCONNECT))
        else $error("led_code set without led_valid");

    a_sleep_pattern: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[6]) |-> (m_tdata[2] && m_tdata[5:3] == LED_SLEEP))
        else $error("sleep request without sleep pattern");

    a_mode_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[8:7] != 2'd3))
        else $error("distance mode out of range");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_tvalid)
        else $error("event lost between stages");
`endif

endmodule

/* hw/rtl/pkc_cfg_regs.sv */
module pkc_cfg_regs
    import pkc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_wr_t wr,
    output cfg_t    cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr.valid) begin
            case (wr.index)
                REG_THR_ZERO:     cfg_next.thr_zero     = wr.data[7:0];
                REG_THR_ONE:      cfg_next.thr_one      = wr.data[7:0];
                REG_THR_TWO:      cfg_next.thr_two      = wr.data[7:0];
                REG_KEEP_LEN:     cfg_next.keep_len     = wr.data;
                REG_IDLE_LIMIT:   cfg_next.idle_limit   = wr.data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.thr_zero     <= THR_RST;
            cfg_reg.thr_one      <= THR_RST;
            cfg_reg.thr_two      <= THR_RST;
            cfg_reg.keep_len     <= KEEP_LEN_RST;
            cfg_reg.idle_limit   <= IDLE_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/pkc_core.sv */
module pkc_core
    import pkc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  cfg_wr_t wr,
    input  logic    step,
    input  item_t   item,
    output result_t res
);

    logic [2:0]  link_status_reg,    link_status_next;
    logic [2:0]  handled_status_reg, handled_status_next;
    logic [7:0]  last_rssi_reg,      last_rssi_next;
    logic [1:0]  distance_mode_reg,  distance_mode_next;
    logic [15:0] keep_countdown_reg, keep_countdown_next;
    logic        keep_switch_reg,    keep_switch_next;
    logic        power_flag_reg,     power_flag_next;
    logic [15:0] idle_count_reg,     idle_count_next;
    logic        power_level_reg,    power_level_next;
    logic        lock_level_reg,     lock_level_next;

    logic signed [7:0] thr_sel;
    logic              rssi_above;
    logic              led_valid;
    logic [2:0]        led_code;
    logic              sleep_req;
    logic              mode_changed;
    logic              ks_tick;

    always_comb begin
        case (distance_mode_reg)
            2'd1:    thr_sel = cfg.thr_one;
            2'd2:    thr_sel = cfg.thr_two;
            default: thr_sel = cfg.thr_zero;
        endcase
        rssi_above = thr_sel < $signed(last_rssi_reg);
    end

    always_comb begin
        link_status_next    = link_status_reg;
        handled_status_next = handled_status_reg;
        last_rssi_next      = last_rssi_reg;
        distance_mode_next  = distance_mode_reg;
        keep_countdown_next = keep_countdown_reg;
        keep_switch_next    = keep_switch_reg;
        power_flag_next     = power_flag_reg;
        idle_count_next     = idle_count_reg;
        power_level_next    = power_level_reg;
        lock_level_next     = lock_level_reg;
        led_valid           = 1'b0;
        led_code            = LED_DISCONNECT;
        sleep_req           = 1'b0;
        mode_changed        = 1'b0;
        ks_tick             = keep_switch_reg;

        if (wr.valid) begin
            // idle countdown follows a new timeout so it stays idle
            if (wr.index == REG_KEEP_LEN && keep_countdown_reg == cfg.keep_len) begin
                keep_countdown_next = wr.data;
            end
            if (wr.index == REG_INITIAL_MODE) begin
                distance_mode_next = (wr.data[1:0] == 2'd3) ? MODE_RST : wr.data[1:0];
            end
        end else if (step) begin
            case (item.func)
                FUNC_TICK: begin
                    if (power_flag_reg) begin
                        keep_countdown_next = cfg.keep_len;
                    end else begin
                        if (keep_countdown_reg <= KEEP_END_TICKS) begin
                            ks_tick = 1'b0;
                        end
                        keep_switch_next = ks_tick;
                        if (keep_countdown_reg != cfg.keep_len) begin
                            // keep-unlock running
                            if (ks_tick) begin
                                keep_countdown_next = keep_countdown_reg - 16'd1;
                            end else begin
                                keep_countdown_next = cfg.keep_len;
                                handled_status_next = ST_UNKNOWN;
                            end
                        end else begin
                            if (link_status_reg != handled_status_reg) begin
                                case (link_status_reg)
                                    ST_ADV: begin
                                        led_valid        = 1'b1;
                                        led_code         = LED_DISCONNECT;
                                        power_level_next = 1'b0;
                                        lock_level_next  = 1'b0;
                                    end
                                    ST_CONNECTED: begin
                                        if (rssi_above) begin
                                            led_valid        = 1'b1;
                                            led_code         = LED_CONNECTED;
                                            power_level_next = 1'b1;
                                            lock_level_next  = 1'b1;
                                        end
                                    end
                                    ST_DISCONNECTED: begin
                                        power_level_next = 1'b0;
                                        lock_level_next  = 1'b0;
                                    end
                                    ST_PAIRING: begin
                                        led_valid = 1'b1;
                                        led_code  = LED_PAIRING;
                                    end
                                    ST_UNPAIRED: begin
                                        led_valid = 1'b1;
                                        led_code  = LED_UNPAIRED;
                                    end
                                    default: ;
                                endcase
                                handled_status_next = link_status_reg;
                            end
                            if (link_status_reg == ST_ADV) begin
                                if (idle_count_reg == cfg.idle_limit) begin
                                    led_valid       = 1'b1;
                                    led_code        = LED_SLEEP;
                                    sleep_req       = 1'b1;
                                    idle_count_next = '0;
                                end else begin
                                    idle_count_next = idle_count_reg + 16'd1;
                                end
                            end else if (link_status_reg == ST_CONNECTED ||
                                         link_status_reg == ST_DISCONNECTED) begin
                                idle_count_next = '0;
                            end
                        end
                    end
                end
                FUNC_STATUS: link_status_next = item.event_code;
                FUNC_RSSI:   last_rssi_next   = item.rssi;
                FUNC_KEY: begin
                    case (item.event_code)
                        KEY_KEEP: begin
                            if (item.switch_on && !power_flag_reg) begin
                                keep_switch_next    = 1'b1;
                                led_valid           = 1'b1;
                                led_code            = LED_KEEP;
                                keep_countdown_next = cfg.keep_len - 16'd1;
                            end else begin
                                keep_switch_next = 1'b0;
                            end
                        end
                        KEY_POWER: begin
                            power_level_next = item.switch_on;
                            lock_level_next  = item.switch_on;
                            power_flag_next  = item.switch_on;
                            led_valid        = 1'b1;
                            led_code         = item.switch_on ? LED_OPEN : LED_CLOSE;
                        end
                        KEY_UNLOCK: lock_level_next = 1'b1;
                        default: ;
                    endcase
                end
                FUNC_MODE: begin
                    distance_mode_next = (distance_mode_reg >= MODE_LAST) ? 2'd0
                                                                         : distance_mode_reg + 2'd1;
                    mode_changed = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_status_reg    <= ST_UNKNOWN;
            handled_status_reg <= ST_UNKNOWN;
            last_rssi_reg      <= '0;
            distance_mode_reg  <= MODE_RST;
            keep_countdown_reg <= KEEP_LEN_RST;
            keep_switch_reg    <= 1'b0;
            power_flag_reg     <= 1'b0;
            idle_count_reg     <= '0;
            power_level_reg    <= 1'b0;
            lock_level_reg     <= 1'b0;
        end else begin
            link_status_reg    <= link_status_next;
            handled_status_reg <= handled_status_next;
            last_rssi_reg      <= last_rssi_next;
            distance_mode_reg  <= distance_mode_next;
            keep_countdown_reg <= keep_countdown_next;
            keep_switch_reg    <= keep_switch_next;
            power_flag_reg     <= power_flag_next;
            idle_count_reg     <= idle_count_next;
            power_level_reg    <= power_level_next;
            lock_level_reg     <= lock_level_next;
        end
    end

    always_comb begin
        res.power_on      = power_level_next;
        res.lock_on       = lock_level_next;
        res.led_valid     = led_valid;
        res.led_code      = led_code;
        res.sleep_request = sleep_req;
        res.mode_now      = distance_mode_next;
        res.mode_changed  = mode_changed;
    end

endmodule

/* hw/rtl/pkc_out_reg.sv */
module pkc_out_reg
    import pkc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  result_t                res,
    output logic                   space,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign space = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(TDATA_OUT_W - $bits(result_t)){1'b0}}, res_reg};

endmodule
